FILE: design/svto_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types of the sine voice.
package svto_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int SINE_TABLE_BITS = 10;
    localparam int SAMPLE_BITS     = 16;

    localparam int FREQ_W    = 30;
    localparam int LEVEL_W   = 16;
    localparam int TAIL_W    = 17;
    localparam int RATE_W    = 36;
    localparam int FACTOR_W  = 16;
    localparam int NOTE_W    = 7;
    localparam int VEL_W     = 7;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [MODE_W-1:0] MODE_TICK     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NOTE_ON  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OFF_TAIL = 2'd2;
    localparam logic [MODE_W-1:0] MODE_OFF_NOW  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_RATE_RECIP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP       = 2'd2;

    localparam logic [RATE_W-1:0]   RATE_RECIP_RST = 36'd5864062015;
    localparam logic [FACTOR_W-1:0] DECAY_RST      = 16'd64881;
    localparam logic [FACTOR_W-1:0] STOP_RST       = 16'd328;

    typedef struct packed {
        logic [MODE_W-1:0]  kind;
        logic [FREQ_W-1:0]  freq;
        logic [LEVEL_W-1:0] level;
    } t_cmd;

    typedef struct packed {
        logic [RATE_W-1:0]   rate_recip;
        logic [FACTOR_W-1:0] decay;
        logic [FACTOR_W-1:0] stop_level;
    } t_cfg;

endpackage

FILE: design/svto_front.sv
`timescale 1ns / 1ps
// Front end: accepts items, looks up note frequency and level, queues commands.
module svto_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [svto_pkg::MODE_W-1:0]    i_mode,
    input  logic [svto_pkg::NOTE_W-1:0]    i_note,
    input  logic [svto_pkg::VEL_W-1:0]     i_velocity,
    output logic                           o_cmd_valid,
    input  logic                           i_cmd_ready,
    output svto_pkg::t_cmd                 o_cmd
);
    import svto_pkg::*;

    localparam int NOTE_COUNT  = 2 ** NOTE_W;
    localparam int VEL_COUNT   = 2 ** VEL_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef logic [FREQ_W-1:0]  t_freq_rom  [NOTE_COUNT];
    typedef logic [LEVEL_W-1:0] t_level_rom [VEL_COUNT];

    function automatic t_freq_rom build_freq_rom();
        t_freq_rom         rom;
        logic [FREQ_W-1:0] top_oct [12];
        logic [31:0]       t;
        int                sh;
        top_oct = '{30'd548668578, 30'd581294109, 30'd615859655, 30'd652480576,
                    30'd691279090, 30'd732384684, 30'd775934544, 30'd822074013,
                    30'd870957077, 30'd922746880, 30'd977616265, 30'd1035748353};
        for (int n = 0; n < NOTE_COUNT; n++) begin
            sh = 10 - n / 12;
            t  = 32'(top_oct[n % 12]);
            if (sh == 0) begin
                rom[n] = FREQ_W'(t);
            end else begin
                rom[n] = FREQ_W'((t + (32'd1 << (sh - 1))) >> sh);
            end
        end
        return rom;
    endfunction

    function automatic t_level_rom build_level_rom();
        t_level_rom rom;
        for (int v = 0; v < VEL_COUNT; v++) begin
            rom[v] = LEVEL_W'((v * 98304 + 635) / 1270);
        end
        return rom;
    endfunction

    localparam t_freq_rom  FREQ_ROM  = build_freq_rom();
    localparam t_level_rom LEVEL_ROM = build_level_rom();

    t_cmd             r_queue [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;
    t_cmd             w_cmd;

    assign o_ready     = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_queue[r_rd_ptr];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_comb begin
        w_cmd.kind  = i_mode;
        w_cmd.freq  = FREQ_ROM[i_note];
        w_cmd.level = LEVEL_ROM[i_velocity];
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

FILE: design/svto_back.sv
`timescale 1ns / 1ps
// Back end: voice state, phase increment, sine lookup, release and output register.
module svto_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  svto_pkg::t_cfg                      i_cfg,
    input  logic                                i_cmd_valid,
    output logic                                o_cmd_ready,
    input  svto_pkg::t_cmd                      i_cmd,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [svto_pkg::SAMPLE_BITS-1:0] o_sample,
    output logic                                o_voice_active
);
    import svto_pkg::*;

    localparam int TABLE_SIZE = 2 ** SINE_TABLE_BITS;
    localparam int ROM_W      = SAMPLE_BITS - 1;
    localparam int HALF_W     = RATE_W / 2;
    localparam int PROD_W     = FREQ_W + HALF_W;
    localparam int SUM_W      = FREQ_W + RATE_W;
    localparam int STEP_TOP   = 63;
    localparam int MAG_W      = ROM_W + LEVEL_W;
    localparam int TMAG_W     = MAG_W + TAIL_W;
    localparam int TPROD_W    = TAIL_W + FACTOR_W;
    localparam int SCALE_W    = SAMPLE_BITS - 1;
    localparam int TAIL_SHIFT = SAMPLE_BITS + 16;
    localparam logic [TAIL_W-1:0] TAIL_ONE = TAIL_W'(65536);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ON_LO  = 3'd1;
    localparam logic [2:0] ST_ON_HI  = 3'd2;
    localparam logic [2:0] ST_ON_SUM = 3'd3;
    localparam logic [2:0] ST_MAG    = 3'd4;
    localparam logic [2:0] ST_SCALE  = 3'd5;
    localparam logic [2:0] ST_EMIT   = 3'd6;

    typedef logic [ROM_W-1:0] t_sine_rom [TABLE_SIZE];

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom   rom;
        logic [63:0] one_q30;
        logic [63:0] amp;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        one_q30 = 64'd1 << 30;
        amp     = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
        for (int k = 0; k < TABLE_SIZE; k++) begin
            x  = (64'd1686629713 * (64'(2 * k) + 64'd1)) >> (SINE_TABLE_BITS + 1);
            x2 = (x * x) >> 30;
            t  = one_q30;
            t  = one_q30 - (((x2 * t) >> 30) / 64'd110);
            t  = one_q30 - (((x2 * t) >> 30) / 64'd72);
            t  = one_q30 - (((x2 * t) >> 30) / 64'd42);
            t  = one_q30 - (((x2 * t) >> 30) / 64'd20);
            t  = one_q30 - (((x2 * t) >> 30) / 64'd6);
            s      = (x * t) >> 30;
            rom[k] = ROM_W'((s * amp + (64'd1 << 29)) >> 30);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

    logic [2:0]                  r_state;
    logic [2:0]                  n_state;
    logic [FREQ_W-1:0]           r_freq;
    logic [PROD_W-1:0]           r_p0;
    logic [PROD_W-1:0]           r_p1;
    logic [PHASE_BITS-1:0]       r_phase;
    logic [PHASE_BITS-1:0]       r_step;
    logic [LEVEL_W-1:0]          r_note_level;
    logic [TAIL_W-1:0]           r_tail;
    logic                        r_sounding;
    logic [ROM_W-1:0]            r_rom;
    logic [MAG_W-1:0]            r_mag;
    logic [TPROD_W-1:0]          r_tail_prod;
    logic [SCALE_W-1:0]          r_scaled;
    logic                        r_out_valid;
    logic [SAMPLE_BITS-1:0]      r_out_sample;
    logic                        r_out_active;

    logic                        w_pop;
    logic                        w_out_free;
    logic                        w_emit;
    logic [1:0]                  w_quad;
    logic [SINE_TABLE_BITS-1:0]  w_idx;
    logic [SINE_TABLE_BITS-1:0]  w_rom_addr;
    logic [HALF_W-1:0]           w_rate_half;
    logic [PROD_W-1:0]           w_prod;
    logic [SUM_W-1:0]            w_sum;
    logic [TMAG_W-1:0]           w_tail_mag;
    logic [SCALE_W-1:0]          w_scaled;
    logic [TAIL_W-1:0]           w_new_tail;
    logic                        w_stop;
    logic [SAMPLE_BITS-1:0]      w_abs;
    logic [SAMPLE_BITS-1:0]      w_sample;

    assign o_cmd_ready    = (r_state == ST_IDLE);
    assign w_pop          = i_cmd_valid && (r_state == ST_IDLE);
    assign w_out_free     = !r_out_valid || i_ready;
    assign w_emit         = (r_state == ST_EMIT) && w_out_free;

    assign w_quad         = r_phase[PHASE_BITS-1 -: 2];
    assign w_idx          = r_phase[PHASE_BITS-3 -: SINE_TABLE_BITS];
    assign w_rom_addr     = w_quad[0] ? ~w_idx : w_idx;

    assign w_rate_half    = (r_state == ST_ON_LO) ? i_cfg.rate_recip[HALF_W-1:0]
                                                  : i_cfg.rate_recip[RATE_W-1:HALF_W];
    assign w_prod         = PROD_W'(r_freq) * PROD_W'(w_rate_half);
    assign w_sum          = SUM_W'(r_p0) + (SUM_W'(r_p1) << HALF_W);

    assign w_tail_mag     = TMAG_W'(r_mag) * TMAG_W'(r_tail);
    assign w_scaled       = (r_tail != '0) ? w_tail_mag[TAIL_SHIFT +: SCALE_W]
                                           : r_mag[SAMPLE_BITS +: SCALE_W];
    assign w_new_tail     = r_tail_prod[FACTOR_W +: TAIL_W];
    assign w_stop         = (r_tail != '0) && (w_new_tail <= TAIL_W'(i_cfg.stop_level));
    assign w_abs          = {1'b0, r_scaled};
    assign w_sample       = w_quad[1] ? (~w_abs + SAMPLE_BITS'(1)) : w_abs;

    assign o_valid        = r_out_valid;
    assign o_sample       = r_out_sample;
    assign o_voice_active = r_out_active;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_pop && i_cmd.kind == MODE_NOTE_ON) begin
                    n_state = ST_ON_LO;
                end else if (w_pop && i_cmd.kind == MODE_TICK) begin
                    n_state = ST_MAG;
                end
            end
            ST_ON_LO:  n_state = ST_ON_HI;
            ST_ON_HI:  n_state = ST_ON_SUM;
            ST_ON_SUM: n_state = ST_IDLE;
            ST_MAG:    n_state = ST_SCALE;
            ST_SCALE:  n_state = ST_EMIT;
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= '0;
            r_step       <= '0;
            r_note_level <= '0;
            r_tail       <= '0;
            r_sounding   <= 1'b0;
        end else begin
            if (w_pop) begin
                unique case (i_cmd.kind)
                    MODE_TICK: begin
                    end
                    MODE_NOTE_ON: begin
                        r_phase      <= '0;
                        r_tail       <= '0;
                        r_note_level <= i_cmd.level;
                        r_sounding   <= 1'b1;
                    end
                    MODE_OFF_TAIL: begin
                        if (r_sounding && r_tail == '0) begin
                            r_tail <= TAIL_ONE;
                        end
                    end
                    MODE_OFF_NOW: begin
                        r_sounding <= 1'b0;
                        r_step     <= '0;
                        r_tail     <= '0;
                    end
                endcase
            end
            if (r_state == ST_ON_SUM) begin
                r_step <= w_sum[STEP_TOP -: PHASE_BITS];
            end
            if (w_emit && r_sounding) begin
                r_phase <= r_phase + r_step;
                if (w_stop) begin
                    r_sounding <= 1'b0;
                    r_step     <= '0;
                    r_tail     <= '0;
                end else if (r_tail != '0) begin
                    r_tail <= w_new_tail;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_freq <= i_cmd.freq;
        end
        if (r_state == ST_IDLE) begin
            r_rom <= SINE_ROM[w_rom_addr];
        end
        if (r_state == ST_ON_LO) begin
            r_p0 <= w_prod;
        end
        if (r_state == ST_ON_HI) begin
            r_p1 <= w_prod;
        end
        if (r_state == ST_MAG) begin
            r_mag       <= MAG_W'(r_rom) * MAG_W'(r_note_level);
            r_tail_prod <= TPROD_W'(r_tail) * TPROD_W'(i_cfg.decay);
        end
        if (r_state == ST_SCALE) begin
            r_scaled <= w_scaled;
        end
        if (w_emit) begin
            r_out_sample <= r_sounding ? w_sample : '0;
            r_out_active <= r_sounding && !w_stop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

FILE: design/sine_voice_with_tail_off_top.sv
`timescale 1ns / 1ps
// Top level of the sine voice: ports, configuration registers, front and back ends.
//
// One synthesizer voice driven by a command stream. The slave stream carries
// the command kind in tuser (tick, note on, note off with release, note off
// immediate) and note and velocity in tdata. Every tick gives one transfer on
// the master stream: a signed Q1.15 sample and the voice-active flag.
// Configuration (rate reciprocal, decay factor, stop level) is written over
// the cfg channel, which is always ready; write it only while the voice is idle.
// Commands enter a two-entry queue; the back end takes one at a time.
// A tick's result passes through the queue, then the back end's magnitude,
// scale and emit states, into the output register. In the back end a tick
// takes the sine ROM read and the two registered multiplies per sample, a
// note on the two halves of the phase increment multiply and their sum, and a
// note off acts as it is taken; a new command is taken only when it is idle.
// Reset clears the voice to silence and loads the default configuration.
// When the receiver stalls, the result holds in the output register, the back
// end waits on its next tick, and tready drops once the queue is full.
module sine_voice_with_tail_off_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [15:0]                       i_s_axis_tdata,  // note[6:0], velocity[13:7]
    input  logic [svto_pkg::MODE_W-1:0]       i_s_axis_tuser,  // mode[1:0]
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [23:0]                       o_m_axis_tdata,  // sample[15:0], voice_active[16]
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [svto_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [svto_pkg::RATE_W-1:0]       i_cfg_data
);
    import svto_pkg::*;

    t_cfg                    r_cfg;
    t_cmd                    w_cmd;
    logic                    w_cmd_valid;
    logic                    w_cmd_ready;
    logic                    w_cfg_write;
    logic [SAMPLE_BITS-1:0]  w_sample;
    logic                    w_voice_active;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_write = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate_recip <= RATE_RECIP_RST;
            r_cfg.decay      <= DECAY_RST;
            r_cfg.stop_level <= STOP_RST;
        end else if (w_cfg_write) begin
            case (i_cfg_index)
                CFG_RATE_RECIP: r_cfg.rate_recip <= i_cfg_data;
                CFG_DECAY:      r_cfg.decay      <= i_cfg_data[FACTOR_W-1:0];
                CFG_STOP:       r_cfg.stop_level <= i_cfg_data[FACTOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    svto_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_mode      (i_s_axis_tuser),
        .i_note      (i_s_axis_tdata[NOTE_W-1:0]),
        .i_velocity  (i_s_axis_tdata[NOTE_W +: VEL_W]),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    svto_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_cmd_valid    (w_cmd_valid),
        .o_cmd_ready    (w_cmd_ready),
        .i_cmd          (w_cmd),
        .o_valid        (o_m_axis_tvalid),
        .i_ready        (i_m_axis_tready),
        .o_sample       (w_sample),
        .o_voice_active (w_voice_active)
    );

    assign o_m_axis_tdata = {7'd0, w_voice_active, w_sample};

endmodule
